FILE: hdl/skf_pkg.sv
// skf_pkg: shared constants and checked add/subtract for the scalar q16.16 kalman filter
// no dependencies
`default_nettype none
package skf_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned CfgW  = 31;
    localparam int unsigned IdxW  = 2;
    localparam logic [DataW-1:0] FxOne      = 32'h0001_0000;
    localparam logic [DataW-1:0] FxOverflow = 32'h8000_0000;

    // configuration register indexes
    localparam logic [IdxW-1:0] RegProcNoise = 2'd0;
    localparam logic [IdxW-1:0] RegMeasNoise = 2'd1;
    localparam logic [IdxW-1:0] RegInitCov   = 2'd2;

    // checked add with overflow marker
    function automatic logic [DataW-1:0] fx_add(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
        logic [DataW-1:0] s;
        s = a + b;
        if (!(a[DataW-1] ^ b[DataW-1]) && (a[DataW-1] ^ s[DataW-1]))
            return FxOverflow;
        return s;
    endfunction

    // checked subtract with overflow marker
    function automatic logic [DataW-1:0] fx_sub(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
        logic [DataW-1:0] d;
        d = a - b;
        if ((a[DataW-1] ^ b[DataW-1]) && (a[DataW-1] ^ d[DataW-1]))
            return FxOverflow;
        return d;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/skf_mul.sv
// skf_mul: bit-serial signed q16.16 multiplier, one multiplier bit per cycle
// depends on skf_pkg
`default_nettype none
module skf_mul import skf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DataW-1:0] a,
    input  wire logic [DataW-1:0] b,
    output logic                  done,
    output logic [DataW-1:0]      result
);
    localparam int unsigned PW = 2 * DataW;
    localparam int unsigned CntW = $clog2(DataW + 1);

    logic [PW-1:0]   acc_reg, acc_next;
    logic [DataW-1:0] mcand_reg, mcand_next;   // |a|
    logic [DataW-1:0] mplier_reg, mplier_next; // |b|, shifted right
    logic            neg_reg, neg_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DataW-1:0] res_reg, res_next;
    logic [DataW:0]  psum;
    logic [PW-1:0]   u;
    logic [DataW-1:0] rnd;

    // partial sum on the upper half of the accumulator
    assign psum = {1'b0, acc_reg[PW-1:DataW]} +
                  {1'b0, (mplier_reg[0] ? mcand_reg : {DataW{1'b0}})};

    // signed result from magnitude product; negating and then decrementing
    // the magnitude is the same as inverting it
    always_comb begin
        u   = acc_reg ^ {PW{neg_reg}};
        rnd = u[DataW+15:16] + {{(DataW-1){1'b0}}, u[15]};
    end

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        if (start) begin
            acc_next    = '0;
            mcand_next  = a[DataW-1] ? (~a + 1'b1) : a;
            mplier_next = b[DataW-1] ? (~b + 1'b1) : b;
            neg_next    = a[DataW-1] ^ b[DataW-1];
            cnt_next    = '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == CntW'(DataW)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // magnitude bound 2^47 (2^47 exactly allowed only when negative)
                if (acc_reg > {{(PW-48){1'b0}}, 1'b1, 47'd0} ||
                    (acc_reg == {{(PW-48){1'b0}}, 1'b1, 47'd0} && !neg_reg))
                    res_next = FxOverflow;
                else
                    res_next = rnd;
            end else begin
                // add one multiplier bit to the upper half, shift right
                acc_next    = {psum, acc_reg[DataW-1:1]};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    // done is a single pulse
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("mul done held");
    // start kicks the unit busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg) else $error("mul not busy after start");
    // count never passes the width
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= CntW'(DataW)) else $error("mul count range");
`endif
endmodule
`default_nettype wire

FILE: hdl/skf_div.sv
// skf_div: restoring q16.16 divider, one quotient bit per cycle
// depends on skf_pkg
`default_nettype none
module skf_div import skf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DataW-1:0] a,
    input  wire logic [DataW-1:0] b,
    output logic                  done,
    output logic [DataW-1:0]      result
);
    // dividend |a| << 17 has 49 bits
    localparam int unsigned NW   = DataW + 17;
    localparam int unsigned CntW = $clog2(NW + 1);

    logic [NW-1:0]    num_reg, num_next;   // dividend bits, then quotient
    logic [DataW:0]   rem_reg, rem_next;
    logic [DataW-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DataW-1:0] res_reg, res_next;
    logic [DataW:0]   trial;
    logic [DataW:0]   diff;
    logic [NW:0]      mag;
    logic [DataW-1:0] ma;

    assign ma    = a[DataW-1] ? (~a + 1'b1) : a;
    assign trial = {rem_reg[DataW-1:0], num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign mag   = ({1'b0, num_reg} + 1'b1) >> 1;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start) begin
            num_next  = {ma, 17'd0};
            rem_next  = '0;
            den_next  = b[DataW-1] ? (~b + 1'b1) : b;
            neg_next  = a[DataW-1] ^ b[DataW-1];
            zero_next = (b == '0);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == CntW'(NW)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg || mag[NW:DataW-1] != '0)
                    res_next = FxOverflow;
                else if (neg_reg)
                    res_next = ~mag[DataW-1:0] + 1'b1;
                else
                    res_next = mag[DataW-1:0];
            end else begin
                // one restoring step
                if (!diff[DataW]) begin
                    rem_next = diff;
                    num_next = {num_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    num_next = {num_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTH
    // done is a single pulse
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("div done held");
    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !zero_reg) |-> rem_reg < {1'b0, den_reg})
        else $error("div remainder bound");
    // start kicks the unit busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg) else $error("div not busy after start");
`endif
endmodule
`default_nettype wire

FILE: hdl/scalar_kalman_q16_16.sv
// scalar_kalman_q16_16: top level, sequencer and filter state
// depends on skf_pkg, skf_mul, skf_div
//
// Usage: one signed q16.16 sample per s_ transfer, one q16.16 estimate per
// m_ transfer. Configuration writes go through cfg_valid/cfg_ready with
// cfg_index (0 process noise, 1 measurement noise, 2 initial covariance,
// which also clears the estimates) and cfg_data; other indexes are ignored.
// The accepted sample starts the divider in the next cycle; the 49-step serial
// divide of the gain is followed by two serial multiplies (gain times
// residual, then (1-k) times covariance, back to back on one shared
// shift-add multiplier). After the receiver takes the result the sequencer
// returns to idle before it accepts the next sample.
// s_ready is low while a sample is in work or its result still waits on m_;
// a stalled receiver holds m_estimate and m_valid, unless a write to the
// initial covariance clears the estimate. Reset (aresetn low, synchronous)
// clears the estimates and the process noise, sets the covariance and the
// measurement noise to one (FxOne) and drops m_valid.
`default_nettype none
module scalar_kalman_q16_16 import skf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IdxW-1:0]  cfg_index,
    input  wire logic [CfgW-1:0]  cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [DataW-1:0] s_measurement,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [DataW-1:0]      m_estimate
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_MUL_K, ST_MUL_P, ST_OUT
    } state_t;

    state_t           state_reg;
    logic [CfgW-1:0]  q_reg, r_reg;
    logic [DataW-1:0] x_reg, last_reg, p_reg, meas_reg, gain_reg;
    logic             out_valid_reg;
    logic             div_start_reg, div_done, mul_start, mul_done;
    logic [DataW-1:0] mul_a, mul_b, mul_res, div_res;
    logic [DataW-1:0] x_proj, p_proj;

    // projection and covariance prediction
    assign x_proj = x_reg + fx_sub(x_reg, last_reg);
    assign p_proj = fx_add(p_reg, {1'b0, q_reg});

    // operands for the shared multiplier
    always_comb begin
        if (state_reg == ST_DIV) begin
            mul_a = div_res;
            mul_b = fx_sub(meas_reg, x_reg);
        end else begin
            mul_a = fx_sub(FxOne, gain_reg);
            mul_b = p_reg;
        end
    end

    skf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .a(p_reg), .b(fx_add(p_reg, {1'b0, r_reg})),
        .done(div_done), .result(div_res)
    );

    skf_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .result(mul_res)
    );

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_estimate = x_reg;

    // unit starts: divider in the cycle after acceptance, multiplier on done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= s_valid && s_ready;
        end
    end
    assign mul_start = (state_reg == ST_DIV && div_done) ||
                       (state_reg == ST_MUL_K && mul_done);

    // sequencer and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            q_reg         <= '0;
            r_reg         <= CfgW'(FxOne);
            x_reg         <= '0;
            last_reg      <= '0;
            p_reg         <= FxOne;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    RegProcNoise: q_reg <= cfg_data;
                    RegMeasNoise: r_reg <= cfg_data;
                    RegInitCov: begin
                        p_reg    <= {1'b0, cfg_data};
                        x_reg    <= '0;
                        last_reg <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        meas_reg <= s_measurement;
                        x_reg    <= x_proj;
                        last_reg <= x_proj;
                        p_reg    <= p_proj;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        gain_reg  <= div_res;
                        state_reg <= ST_MUL_K;
                    end
                end
                ST_MUL_K: begin
                    if (mul_done) begin
                        x_reg     <= x_reg + mul_res;
                        state_reg <= ST_MUL_P;
                    end
                end
                ST_MUL_P: begin
                    if (mul_done) begin
                        p_reg         <= mul_res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // result shown only in the output state
    a_valid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT) else $error("m_valid outside output");
    // stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_estimate)))
        else $error("result changed under stall");
    // an accepted sample starts the divider next cycle
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> div_start_reg) else $error("divider not started");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/scalar_kalman_q16_16_tb.sv
// scalar_kalman_q16_16_tb: self-checking bench for the scalar q16.16 kalman filter
// depends on skf_pkg and scalar_kalman_q16_16; predicts every estimate in a scoreboard class
`timescale 1ns / 100ps
`default_nettype none
module scalar_kalman_q16_16_tb;
    import skf_pkg::*;

    // index with no register behind it
    localparam logic [IdxW-1:0] RegUnused = 2'd3;

    // filter predictor and queue of pending estimates
    class kalman_scoreboard;
        logic [31:0] proc_noise, meas_noise, init_cov;
        logic [31:0] x_est, x_prev, cov;
        logic [31:0] pending_est[$];
        int errors;

        function new();
            proc_noise = 0;
            meas_noise = 32'h0001_0000;
            init_cov   = 32'h0001_0000;
            x_est = 0;
            x_prev = 0;
            cov = init_cov;
            errors = 0;
        endfunction

        function logic [31:0] chk_add(logic [31:0] a, logic [31:0] b);
            logic [31:0] s;
            s = a + b;
            if (!(a[31] ^ b[31]) && (a[31] ^ s[31])) return FxOverflow;
            return s;
        endfunction

        function logic [31:0] chk_sub(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            if ((a[31] ^ b[31]) && (a[31] ^ d[31])) return FxOverflow;
            return d;
        endfunction

        function logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
            logic signed [63:0] prod;
            logic [63:0] u;
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            if (prod >= (64'sd1 <<< 47) || prod < -(64'sd1 <<< 47)) return FxOverflow;
            u = prod;
            if (prod < 0) u = u - 1;
            return u[47:16] + {31'd0, u[15]};
        endfunction

        function logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
            logic [63:0] ma, mb, q, mag;
            if (b == 0) return FxOverflow;
            ma = a[31] ? {32'd0, -a} : {32'd0, a};
            mb = b[31] ? {32'd0, -b} : {32'd0, b};
            if (ma == 0 && a[31]) ma = 64'h8000_0000;
            if (mb == 0) mb = 64'h8000_0000;
            q = (ma << 17) / mb;
            mag = (q + 1) >> 1;
            if (mag >= 64'h8000_0000) return FxOverflow;
            if (a[31] ^ b[31]) return -mag[31:0];
            return mag[31:0];
        endfunction

        function void write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
            case (idx)
                RegProcNoise: proc_noise = {1'b0, data};
                RegMeasNoise: meas_noise = {1'b0, data};
                RegInitCov: begin
                    init_cov = {1'b0, data};
                    cov = init_cov;
                    x_est = 0;
                    x_prev = 0;
                end
                default: ;
            endcase
        endfunction

        // one filter step per accepted sample
        function void note_sample(logic [31:0] meas);
            logic [31:0] gain;
            x_est = x_est + chk_sub(x_est, x_prev);
            x_prev = x_est;
            cov = chk_add(cov, proc_noise);
            gain = q_div(cov, chk_add(cov, meas_noise));
            x_est = x_est + q_mul(gain, chk_sub(meas, x_est));
            cov = q_mul(chk_sub(FxOne, gain), cov);
            pending_est.push_back(x_est);
        endfunction

        function void check_estimate(logic [31:0] got);
            logic [31:0] want;
            if (pending_est.size() == 0) begin
                $display("%0t: unexpected estimate %h", $time, got);
                errors++;
                return;
            end
            want = pending_est.pop_front();
            if (got !== want) begin
                $display("%0t: estimate mismatch expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [IdxW-1:0] cfg_index;
    logic [CfgW-1:0] cfg_data;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [DataW-1:0] s_measurement, m_estimate;

    kalman_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    int idle_cycles;

    scalar_kalman_q16_16 u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_measurement(s_measurement),
        .m_valid(m_valid), .m_ready(m_ready), .m_estimate(m_estimate)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // receiver side: random stalls and result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_estimate(m_estimate);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL scalar_kalman_q16_16");
            $finish;
        end
    end

    // drop valid after the transfer and wait for the next edge so that the next drive lands in a new step
    task automatic send_sample(logic [31:0] meas);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1;
        s_measurement <= meas;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(meas);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    // wait until all estimates have come back plus the block latency
    task automatic drain();
        while (sb.pending_est.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_meas(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            default: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    task automatic random_phase(int n, int walk);
        logic [31:0] base;
        base = rand_meas(2);
        repeat (n) begin
            if (walk != 0 && $urandom_range(9) != 0) begin
                base = base + rand_meas(1);
                send_sample(base);
            end else begin
                send_sample(rand_meas($urandom_range(2)));
            end
        end
    endtask

    initial begin
        logic [31:0] dir_vals[10];
        sb = new();
        aresetn = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; s_measurement = 0; m_ready = 0;
        idle_cycles = 0;
        send_idle_pct = 16; recv_idle_pct = 65;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes under reset settings
        dir_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_0000,
                     32'h1234_5678};
        foreach (dir_vals[i]) send_sample(dir_vals[i]);
        drain();

        // division by zero: zero covariance and zero measurement noise
        write_reg(RegMeasNoise, 31'd0);
        write_reg(RegProcNoise, 31'd0);
        write_reg(RegInitCov, 31'd0);
        send_sample(32'h0003_0000);
        send_sample(32'h8000_0000);
        drain();

        // extreme noise values, overflow of the covariance sum
        write_reg(RegProcNoise, 31'h7FFF_FFFF);
        write_reg(RegMeasNoise, 31'h7FFF_FFFF);
        write_reg(RegInitCov, 31'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0);
        drain();
        write_reg(RegUnused, 31'h1234);  // ignored index
        send_sample(32'h0005_0000);
        drain();

        // random phases across settings and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin send_idle_pct = 65; recv_idle_pct = 16; end
            if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_reg(RegProcNoise, (ph % 4 == 0) ? 31'd0
                                                  : CfgW'($urandom_range(32'h0002_0000)));
            write_reg(RegMeasNoise, (ph == 5) ? 31'h7FFF_FFFF
                                              : (ph == 2 ? 31'd0
                                                         : CfgW'($urandom_range(32'h0010_0000))));
            write_reg(RegInitCov, (ph == 7) ? 31'h7FFF_FFFF : CfgW'($urandom));
            random_phase(48, ph % 3);
            drain();
        end

        if (sb.errors == 0)
            $display("PASS scalar_kalman_q16_16");
        else
            $display("FAIL scalar_kalman_q16_16");
        $finish;
    end
endmodule
`default_nettype wire
